FILE: design/cbfm_pkg.sv
package cbfm_pkg;

  // Table geometry
  localparam int MAX_BANDS = 16;
  localparam int AW        = $clog2(MAX_BANDS);

  // Fixed field widths
  localparam int FREQ_W = 30;
  localparam int STEP_W = 24;
  localparam int CHAN_W = 16;
  localparam int QF_W   = 32;
  localparam int BC_W   = 5;
  localparam int IDX_W  = 4;
  localparam int LIM_W  = FREQ_W + 1;

  // Shared restoring divider: 32-bit dividend, one quotient bit per cycle
  localparam int DIV_W  = QF_W;
  localparam int DCNT_W = $clog2(DIV_W);

  // Configuration register index (byte address bit 2)
  localparam logic REG_BAND_COUNT = 1'b0;

  typedef enum logic [1:0] {
    REQ_WRITE = 2'd0,
    REQ_C2F   = 2'd1,
    REQ_F2C   = 2'd2,
    REQ_NONE  = 2'd3
  } req_e;

  typedef enum logic [2:0] {
    ST_IDLE,
    ST_WDIV,
    ST_WSTORE,
    ST_SEARCH,
    ST_MUL,
    ST_QDIV,
    ST_RESULT
  } state_e;

  // One band as kept in the table memory. span is the last channel offset
  // (last - first); limit is (span + 1) * step, the exclusive upper bound of
  // freq - start. en is clear for a zero step or an end a full step or more below start.
  typedef struct packed {
    logic              en;
    logic [FREQ_W-1:0] start;
    logic [STEP_W-1:0] step;
    logic [CHAN_W-1:0] first;
    logic [FREQ_W-1:0] span;
    logic [LIM_W-1:0]  limit;
  } band_entry_t;

  // Memory-side control from the sequencer
  typedef struct packed {
    logic          we;
    logic          re;
    logic [AW-1:0] raddr;
  } mem_ctrl_t;

endpackage

FILE: design/channel_band_frequency_mapper_unit.sv
// Channel band frequency mapper.
//
//   channel | direction | handshake              | payload
//   --------+-----------+------------------------+----------------------------------
//   in      | in        | in_valid_i / in_stall_o  | req_type_i, band_*_i, query_*_i
//   out     | out       | out_valid_o / out_stall_i| found_o, center_freq_o,
//           |           |                        | channel_out_o
//   cfg     | in        | APB psel/penable/pready | band_count at byte address 0
//
// Steps: a band write runs the bit-serial span divide, then one store; a
// channel-to-frequency query reads one table entry per band searched, then one multiply;
// frequency-to-channel runs the bit-serial divide after the search.
// Reset clears sequencer, output valid and band_count; the table has no reset.
// Input stalls while a transaction runs; a result held by out_stall_i blocks
// only the next transaction's result cycle.
module channel_band_frequency_mapper_unit
  import cbfm_pkg::*;
(
  input  logic              clk_i,
  input  logic              rst_ni,

  input  logic              in_valid_i,
  output logic              in_stall_o,
  input  logic [1:0]        req_type_i,
  input  logic [IDX_W-1:0]  band_index_i,
  input  logic [FREQ_W-1:0] band_start_freq_i,
  input  logic [FREQ_W-1:0] band_end_freq_i,
  input  logic [STEP_W-1:0] band_step_freq_i,
  input  logic [CHAN_W-1:0] band_first_channel_i,
  input  logic [CHAN_W-1:0] query_channel_i,
  input  logic [QF_W-1:0]   query_freq_i,

  output logic              out_valid_o,
  input  logic              out_stall_i,
  output logic              found_o,
  output logic [FREQ_W-1:0] center_freq_o,
  output logic [CHAN_W-1:0] channel_out_o,

  input  logic              psel,
  input  logic              penable,
  input  logic              pwrite,
  input  logic [2:0]        paddr,
  input  logic [31:0]       pwdata,
  output logic [31:0]       prdata,
  output logic              pready
);

  // ---------------------------------------------------------------------
  // Configuration
  // ---------------------------------------------------------------------
  logic [BC_W-1:0] band_count_q;
  logic [BC_W-1:0] n_cnt;
  logic            cfg_wr;

  assign pready = 1'b1;
  assign cfg_wr = psel && penable && pwrite && (paddr[2] == REG_BAND_COUNT);
  assign prdata = (paddr[2] == REG_BAND_COUNT) ? 32'(band_count_q) : 32'd0;

  // Counts above the table depth search the whole table
  assign n_cnt = (int'(band_count_q) > MAX_BANDS) ? BC_W'(MAX_BANDS) : band_count_q;

  // ---------------------------------------------------------------------
  // State
  // ---------------------------------------------------------------------
  state_e state_q, state_d;
  mem_ctrl_t mc;

  logic        acc;
  logic        out_free;
  logic        out_load;

  req_e              req_q;
  logic [IDX_W-1:0]  idx_q;
  logic [FREQ_W-1:0] wstart_q, wend_q;
  logic [STEP_W-1:0] wstep_q;
  logic [CHAN_W-1:0] wfirst_q;
  logic [CHAN_W-1:0] qch_q;
  logic [QF_W-1:0]   qfreq_q;

  logic [BC_W-1:0]   iss_q;
  logic              rd_vld_q;
  logic              rd_last_q;
  band_entry_t       rdata_q;

  logic              hit_q;
  logic [FREQ_W-1:0] m_start_q;
  logic [STEP_W-1:0] m_step_q;
  logic [CHAN_W-1:0] m_first_q;
  logic [CHAN_W-1:0] off_q;
  logic [STEP_W+CHAN_W-1:0] prod_q;

  logic [DIV_W-1:0]  dvd_q;
  logic [STEP_W-1:0] rem_q;
  logic [STEP_W-1:0] dsr_q;
  logic [DCNT_W-1:0] div_cnt_q;

  logic              out_valid_q;
  logic              found_q;
  logic [FREQ_W-1:0] center_q;
  logic [CHAN_W-1:0] chan_q;

  band_entry_t mem [MAX_BANDS];

  assign acc      = in_valid_i && !in_stall_o;
  assign out_free = !out_valid_q || !out_stall_i;

  // ---------------------------------------------------------------------
  // Band match on the entry just read
  // ---------------------------------------------------------------------
  logic [CHAN_W:0] off17;
  logic            c_hit, f_hit, f_neg, hit;
  logic [QF_W:0]   fq_lo, fq_hi;

  always_comb begin
    off17 = {1'b0, qch_q} - {1'b0, rdata_q.first};
    c_hit = rdata_q.en && !off17[CHAN_W]
            && ({{(FREQ_W-CHAN_W){1'b0}}, off17[CHAN_W-1:0]} <= rdata_q.span);
    // -step < freq - start < limit
    fq_lo = {1'b0, qfreq_q} + (QF_W+1)'(rdata_q.step);
    fq_hi = (QF_W+1)'(rdata_q.start) + (QF_W+1)'(rdata_q.limit);
    f_hit = rdata_q.en && (fq_lo > (QF_W+1)'(rdata_q.start))
            && ({1'b0, qfreq_q} < fq_hi);
    f_neg = qfreq_q < QF_W'(rdata_q.start);
    hit   = rd_vld_q && ((req_q == REQ_C2F) ? c_hit : f_hit);
  end

  // ---------------------------------------------------------------------
  // Divider step (restoring)
  // ---------------------------------------------------------------------
  logic [STEP_W:0]   rem_sh;
  logic [STEP_W+1:0] div_sub;
  logic              div_ge;

  assign rem_sh  = {rem_q, dvd_q[DIV_W-1]};
  assign div_sub = {1'b0, rem_sh} - (STEP_W+2)'(dsr_q);
  assign div_ge  = !div_sub[STEP_W+1];

  // ---------------------------------------------------------------------
  // Band entry built after the span divide
  // ---------------------------------------------------------------------
  band_entry_t       wentry;
  logic              w_ge;
  logic [FREQ_W-1:0] w_span;
  logic [FREQ_W-1:0] abs_in;

  always_comb begin
    w_ge   = wend_q >= wstart_q;
    w_span = wend_q - wstart_q;
    wentry.start = wstart_q;
    wentry.step  = wstep_q;
    wentry.first = wfirst_q;
    // End below start truncates toward zero: only a zero span survives
    wentry.en    = (wstep_q != '0) && (w_ge || (dvd_q == '0));
    wentry.span  = w_ge ? dvd_q[FREQ_W-1:0] : '0;
    wentry.limit = w_ge ? (LIM_W'(w_span) - LIM_W'(rem_q) + LIM_W'(wstep_q))
                        : LIM_W'(wstep_q);
  end

  assign abs_in = (band_end_freq_i >= band_start_freq_i)
                  ? (band_end_freq_i - band_start_freq_i)
                  : (band_start_freq_i - band_end_freq_i);

  // ---------------------------------------------------------------------
  // Sequencer: next state
  // ---------------------------------------------------------------------
  always_comb begin
    state_d = state_q;
    unique case (state_q)
      ST_IDLE: begin
        if (acc) begin
          case (req_type_i)
            REQ_WRITE: begin
              if (int'(band_index_i) < MAX_BANDS) state_d = ST_WDIV;
            end
            REQ_C2F, REQ_F2C: begin
              state_d = (n_cnt == '0) ? ST_RESULT : ST_SEARCH;
            end
            default: state_d = ST_IDLE;
          endcase
        end
      end
      ST_WDIV: begin
        if (div_cnt_q == '0) state_d = ST_WSTORE;
      end
      ST_WSTORE: state_d = ST_IDLE;
      ST_SEARCH: begin
        if (hit) begin
          if (req_q == REQ_C2F) state_d = ST_MUL;
          else state_d = f_neg ? ST_RESULT : ST_QDIV;
        end else if (rd_vld_q && rd_last_q) begin
          state_d = ST_RESULT;
        end
      end
      ST_MUL: state_d = ST_RESULT;
      ST_QDIV: begin
        if (div_cnt_q == '0) state_d = ST_RESULT;
      end
      ST_RESULT: begin
        if (out_free) state_d = ST_IDLE;
      end
      default: state_d = ST_IDLE;
    endcase
  end

  // ---------------------------------------------------------------------
  // Sequencer: outputs
  // ---------------------------------------------------------------------
  always_comb begin
    in_stall_o = (state_q != ST_IDLE);
    out_load   = (state_q == ST_RESULT) && out_free;
    mc.we      = (state_q == ST_WSTORE);
    mc.re      = (state_q == ST_SEARCH) && (iss_q < n_cnt) && !hit;
    mc.raddr   = iss_q[AW-1:0];
  end

  // ---------------------------------------------------------------------
  // Table memory
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i) begin
    if (mc.we) mem[idx_q[AW-1:0]] <= wentry;
    if (mc.re) rdata_q <= mem[mc.raddr];
  end

  // ---------------------------------------------------------------------
  // Control registers
  // ---------------------------------------------------------------------
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q      <= ST_IDLE;
      band_count_q <= '0;
      out_valid_q  <= 1'b0;
      rd_vld_q     <= 1'b0;
      rd_last_q    <= 1'b0;
      iss_q        <= '0;
      div_cnt_q    <= '0;
    end else begin
      state_q   <= state_d;
      rd_vld_q  <= mc.re;
      // marks the read of the last band in the search range
      rd_last_q <= mc.re && (iss_q == n_cnt - BC_W'(1));
      if (cfg_wr) band_count_q <= pwdata[BC_W-1:0];
      if (out_load) out_valid_q <= 1'b1;
      else if (!out_stall_i) out_valid_q <= 1'b0;
      if (acc) iss_q <= '0;
      else if (mc.re) iss_q <= iss_q + BC_W'(1);
      if (acc || (state_q == ST_SEARCH && hit)) div_cnt_q <= DCNT_W'(DIV_W - 1);
      else if (state_q == ST_WDIV || state_q == ST_QDIV) div_cnt_q <= div_cnt_q - DCNT_W'(1);
    end
  end

  // ---------------------------------------------------------------------
  // Datapath registers
  // ---------------------------------------------------------------------
  logic [DIV_W:0] ch33;

  assign ch33 = (DIV_W+1)'(dvd_q) + (DIV_W+1)'(m_first_q);

  always_ff @(posedge clk_i) begin
    if (acc) begin
      req_q    <= req_e'(req_type_i);
      idx_q    <= band_index_i;
      wstart_q <= band_start_freq_i;
      wend_q   <= band_end_freq_i;
      wstep_q  <= band_step_freq_i;
      wfirst_q <= band_first_channel_i;
      qch_q    <= query_channel_i;
      qfreq_q  <= query_freq_i;
      // span divide loads here; queries reload on a match
      dvd_q    <= DIV_W'(abs_in);
      rem_q    <= '0;
      dsr_q    <= band_step_freq_i;
      hit_q    <= 1'b0;
    end else if (state_q == ST_SEARCH && hit) begin
      m_start_q <= rdata_q.start;
      m_step_q  <= rdata_q.step;
      m_first_q <= rdata_q.first;
      off_q     <= off17[CHAN_W-1:0];
      hit_q     <= 1'b1;
      // frequency below start but within one step: quotient is zero
      dvd_q     <= f_neg ? '0 : (qfreq_q - QF_W'(rdata_q.start));
      rem_q     <= '0;
      dsr_q     <= rdata_q.step;
    end else if (state_q == ST_WDIV || state_q == ST_QDIV) begin
      dvd_q <= {dvd_q[DIV_W-2:0], div_ge};
      rem_q <= div_ge ? div_sub[STEP_W-1:0] : rem_sh[STEP_W-1:0];
    end
    if (state_q == ST_MUL) begin
      prod_q <= (STEP_W+CHAN_W)'(m_step_q) * (STEP_W+CHAN_W)'(off_q);
    end
    // output payload changes only when a result is loaded
    if (out_load) begin
      if (!hit_q) begin
        found_q  <= 1'b0;
        center_q <= '0;
        chan_q   <= '0;
      end else if (req_q == REQ_C2F) begin
        found_q  <= 1'b1;
        center_q <= m_start_q + prod_q[FREQ_W-1:0];
        chan_q   <= '0;
      end else begin
        center_q <= '0;
        found_q  <= (ch33[DIV_W:CHAN_W] == '0);
        chan_q   <= (ch33[DIV_W:CHAN_W] == '0) ? ch33[CHAN_W-1:0] : '0;
      end
    end
  end

  assign out_valid_o   = out_valid_q;
  assign found_o       = found_q;
  assign center_freq_o = center_q;
  assign channel_out_o = chan_q;

`ifndef SYNTH
  a_result_from_seq: assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(out_valid_q) |-> $past(state_q == ST_RESULT))
    else $error("result loaded outside result state");

  a_miss_zero: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && !found_o) |-> (center_freq_o == '0 && channel_out_o == '0))
    else $error("miss carries nonzero payload");

  a_one_mode: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (out_valid_o && found_o) |-> (center_freq_o == '0 || channel_out_o == '0))
    else $error("both frequency and channel set");

  a_read_in_search: assert property (@(posedge clk_i) disable iff (!rst_ni)
    rd_vld_q |-> (state_q == ST_SEARCH && iss_q <= n_cnt))
    else $error("table read outside band search");
`endif

endmodule

FILE: tb/testbench.sv
`timescale 1ns / 1ps

import cbfm_pkg::*;

localparam longint FREQ_MAX = (longint'(1) << FREQ_W) - 1;
localparam longint STEP_MAX = (longint'(1) << STEP_W) - 1;
localparam longint CHAN_MAX = (longint'(1) << CHAN_W) - 1;
localparam longint QF_MAX   = (longint'(1) << QF_W) - 1;

// One tuning transaction on the input channel.
typedef struct {
  req_e              req;
  bit [IDX_W-1:0]    index;
  bit [FREQ_W-1:0]   start_freq;
  bit [FREQ_W-1:0]   end_freq;
  bit [STEP_W-1:0]   step_freq;
  bit [CHAN_W-1:0]   first_channel;
  bit [CHAN_W-1:0]   channel;
  bit [QF_W-1:0]     freq;
} tune_req_t;

typedef struct {
  logic              found;
  logic [FREQ_W-1:0] center_freq;
  logic [CHAN_W-1:0] channel_out;
} tune_result_t;

class band_map_scoreboard;
  bit [FREQ_W-1:0] start_tab [MAX_BANDS];
  bit [FREQ_W-1:0] end_tab   [MAX_BANDS];
  bit [STEP_W-1:0] step_tab  [MAX_BANDS];
  bit [CHAN_W-1:0] first_tab [MAX_BANDS];
  bit [BC_W-1:0]   band_count;
  tune_result_t    pending_results [$];
  int              mismatches;

  // Applies one transaction to the band table copy; returns 1 when it yields a result.
  function bit map_request(input tune_req_t r, output tune_result_t res);
    int     n;
    int     b;
    longint lo, hi, ch, step;
    res.found       = 1'b0;
    res.center_freq = '0;
    res.channel_out = '0;
    if (r.req == REQ_WRITE) begin
      start_tab[r.index] = r.start_freq;
      end_tab[r.index]   = r.end_freq;
      step_tab[r.index]  = r.step_freq;
      first_tab[r.index] = r.first_channel;
      return 1'b0;
    end
    if (r.req == REQ_NONE) return 1'b0;
    n = (int'(band_count) > MAX_BANDS) ? MAX_BANDS : int'(band_count);
    for (b = 0; b < n; b++) begin
      if (step_tab[b] == 0) continue;
      step = longint'(step_tab[b]);
      lo   = longint'(first_tab[b]);
      hi   = lo + (longint'(end_tab[b]) - longint'(start_tab[b])) / step;
      if (r.req == REQ_C2F) ch = longint'(r.channel);
      else ch = (longint'(r.freq) - longint'(start_tab[b])) / step + lo;
      if (lo <= ch && ch <= hi) begin
        if (r.req == REQ_C2F) begin
          res.found       = 1'b1;
          res.center_freq = FREQ_W'(longint'(start_tab[b]) + step * (ch - lo));
        end else if (ch <= CHAN_MAX) begin
          res.found       = 1'b1;
          res.channel_out = CHAN_W'(ch);
        end
        return 1'b1;
      end
    end
    return 1'b1;
  endfunction

  function void note_request(input tune_req_t r);
    tune_result_t res;
    if (map_request(r, res)) pending_results.insert(pending_results.size(), res);
  endfunction

  function void check_result(input tune_result_t got);
    tune_result_t want;
    if (pending_results.size() == 0) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: result with nothing pending: found=%b center=%0d chan=%0d",
                 $time, got.found, got.center_freq, got.channel_out);
      return;
    end
    want = pending_results.pop_front();
    if (got.found !== want.found || got.center_freq !== want.center_freq ||
        got.channel_out !== want.channel_out) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: exp found=%b center=%0d chan=%0d, got found=%b center=%0d chan=%0d",
                 $time, want.found, want.center_freq, want.channel_out,
                 got.found, got.center_freq, got.channel_out);
    end
  endfunction

  function void check_band_count(input logic [BC_W-1:0] got);
    if (got !== band_count) begin
      mismatches++;
      if (mismatches <= 10)
        $display("%0t: band_count readback exp %0d got %0d", $time, band_count, got);
    end
  endfunction
endclass

module testbench;

  localparam logic [2:0] BAND_COUNT_ADDR = {REG_BAND_COUNT, 2'b00};
  // margin after the result queue empties, so a trailing band write can finish
  localparam int DRAIN_CYCLES = 60;
  localparam int NUM_PHASES   = 10;
  localparam int PHASE_ITEMS  = 50;

  logic              clk_i;
  logic              rst_ni;
  logic              in_valid_i;
  logic              in_stall_o;
  logic [1:0]        req_type_i;
  logic [IDX_W-1:0]  band_index_i;
  logic [FREQ_W-1:0] band_start_freq_i;
  logic [FREQ_W-1:0] band_end_freq_i;
  logic [STEP_W-1:0] band_step_freq_i;
  logic [CHAN_W-1:0] band_first_channel_i;
  logic [CHAN_W-1:0] query_channel_i;
  logic [QF_W-1:0]   query_freq_i;
  logic              out_valid_o;
  logic              out_stall_i;
  logic              found_o;
  logic [FREQ_W-1:0] center_freq_o;
  logic [CHAN_W-1:0] channel_out_o;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [2:0]        paddr;
  logic [31:0]       pwdata;
  logic [31:0]       prdata;
  logic              pready;

  // percent chance per cycle that sender gaps / receiver stalls; 0 = full rate
  int                 idle_pct;
  band_map_scoreboard sb;

  channel_band_frequency_mapper_unit uut (.*);

  initial begin
    clk_i = 1'b0;
    forever #10 clk_i = ~clk_i;
  end

  // Hard stop in case the block hangs or drops a result.
  initial begin
    #10_000_000;
    $display("end of test: mismatches");
    $finish;
  end

  // Every field gets random content; callers overwrite what matters.
  function automatic tune_req_t random_fields(input req_e req);
    tune_req_t r;
    r.req           = req;
    r.index         = IDX_W'($urandom);
    r.start_freq    = FREQ_W'($urandom);
    r.end_freq      = FREQ_W'($urandom);
    r.step_freq     = STEP_W'($urandom_range(1, 32'(STEP_MAX)));
    r.first_channel = CHAN_W'($urandom);
    r.channel       = CHAN_W'($urandom);
    r.freq          = $urandom;
    return r;
  endfunction

  // Mostly well-formed bands: end lands on a channel grid point plus some jitter.
  // A few get an unrelated end, or an end just below start.
  function automatic tune_req_t random_band(input int idx);
    tune_req_t r;
    longint    s, e, sp, nch;
    r       = random_fields(REQ_WRITE);
    r.index = IDX_W'(idx);
    sp  = ($urandom_range(99) < 30) ? longint'($urandom_range(1, 32'(STEP_MAX)))
                                    : longint'($urandom_range(1, 200_000));
    s   = longint'(r.start_freq);
    nch = longint'($urandom_range(400));
    if (s + nch * sp > FREQ_MAX) nch = (FREQ_MAX - s) / sp;
    e = s + nch * sp + longint'($urandom_range(32'(sp - 1)));
    if (e > FREQ_MAX) e = FREQ_MAX;
    case ($urandom_range(9))
      0: e = longint'(r.end_freq);
      1: begin
        e = s - longint'($urandom_range(32'(2 * sp)));
        if (e < 0) e = 0;
      end
      default: ;
    endcase
    r.end_freq  = FREQ_W'(e);
    r.step_freq = STEP_W'(sp);
    case ($urandom_range(3))
      0:       r.first_channel = CHAN_W'($urandom_range(65_000, 32'(CHAN_MAX)));
      1, 2:    r.first_channel = CHAN_W'($urandom_range(2000));
      default: ;
    endcase
    return r;
  endfunction

  // Queries aimed at a loaded band: near its first channel, near its last,
  // or anywhere inside. A few stay fully random.
  function automatic tune_req_t random_query(input int n);
    tune_req_t r;
    int        b;
    longint    s, sp, span, off, v;
    r = random_fields($urandom_range(1) ? REQ_F2C : REQ_C2F);
    if ($urandom_range(99) < 8) return r;
    if (n > 0 && $urandom_range(99) < 75)
      b = $urandom_range(((n > MAX_BANDS) ? MAX_BANDS : n) - 1);
    else
      b = $urandom_range(MAX_BANDS - 1);
    s  = longint'(sb.start_tab[b]);
    sp = longint'(sb.step_tab[b]);
    if (sp == 0) sp = 1;
    span = (longint'(sb.end_tab[b]) - s) / sp;
    if (span < 0) span = 0;
    case ($urandom_range(3))
      0:       off = longint'($urandom_range(2)) - 1;
      1:       off = span + longint'($urandom_range(2)) - 1;
      default: off = longint'($urandom_range(32'(span)));
    endcase
    if (r.req == REQ_C2F) begin
      v = longint'(sb.first_tab[b]) + off;
      if (v < 0) v = 0;
      if (v > CHAN_MAX) v = CHAN_MAX;
      r.channel = CHAN_W'(v);
    end else begin
      v = s + off * sp;
      if ($urandom_range(1)) v = v + longint'($urandom_range(32'(sp - 1)));
      else v = v - longint'($urandom_range(32'(sp - 1)));
      if (v < 0) v = 0;
      if (v > QF_MAX) v = QF_MAX;
      r.freq = QF_W'(v);
    end
    return r;
  endfunction

  // Present one transaction and hold it until accepted. Valid only drops
  // when a gap is taken, so back-to-back transactions keep it high.
  task automatic send_item(input tune_req_t r);
    if ($urandom_range(99) < idle_pct) begin
      in_valid_i <= 1'b0;
      do @(posedge clk_i); while ($urandom_range(99) < idle_pct);
    end
    req_type_i           <= r.req;
    band_index_i         <= r.index;
    band_start_freq_i    <= r.start_freq;
    band_end_freq_i      <= r.end_freq;
    band_step_freq_i     <= r.step_freq;
    band_first_channel_i <= r.first_channel;
    query_channel_i      <= r.channel;
    query_freq_i         <= r.freq;
    in_valid_i           <= 1'b1;
    do @(posedge clk_i); while (in_stall_o);
    sb.note_request(r);
  endtask

  task automatic send_band(input int idx, input longint s, input longint e,
                           input longint sp, input longint first);
    tune_req_t r;
    r               = random_fields(REQ_WRITE);
    r.index         = IDX_W'(idx);
    r.start_freq    = FREQ_W'(s);
    r.end_freq      = FREQ_W'(e);
    r.step_freq     = STEP_W'(sp);
    r.first_channel = CHAN_W'(first);
    send_item(r);
  endtask

  task automatic send_query(input req_e req, input longint value);
    tune_req_t r;
    r = random_fields(req);
    if (req == REQ_C2F) r.channel = CHAN_W'(value);
    else r.freq = QF_W'(value);
    send_item(r);
  endtask

  // Stop sending, let every pending result come out, then give a trailing
  // band write time to finish (it has no result to wait for).
  task automatic drain();
    in_valid_i <= 1'b0;
    while (sb.pending_results.size() != 0) @(posedge clk_i);
    repeat (DRAIN_CYCLES) @(posedge clk_i);
  endtask

  // APB write of band_count followed by a readback. Only called while idle.
  task automatic cfg_band_count(input bit [BC_W-1:0] cnt);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= BAND_COUNT_ADDR;
    pwdata  <= 32'(cnt);
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.band_count = cnt;
    penable <= 1'b0;
    pwrite  <= 1'b0;
    @(posedge clk_i);
    penable <= 1'b1;
    do @(posedge clk_i); while (!pready);
    sb.check_band_count(prdata[BC_W-1:0]);
    psel    <= 1'b0;
    penable <= 1'b0;
  endtask

  // Output side: check each accepted result, stall at random.
  initial begin : result_monitor
    tune_result_t got;
    wait (rst_ni === 1'b1);
    forever begin
      @(posedge clk_i);
      if (out_valid_o && !out_stall_i) begin
        got.found       = found_o;
        got.center_freq = center_freq_o;
        got.channel_out = channel_out_o;
        sb.check_result(got);
      end
      out_stall_i <= ($urandom_range(99) < idle_pct);
    end
  end

  initial begin : stimulus
    bit [BC_W-1:0] phase_counts [NUM_PHASES];
    tune_req_t     item;
    int            ph, i, sent, pick;

    sb = new;
    rst_ni               = 1'b0;
    in_valid_i           = 1'b0;
    req_type_i           = REQ_NONE;
    band_index_i         = '0;
    band_start_freq_i    = '0;
    band_end_freq_i      = '0;
    band_step_freq_i     = '0;
    band_first_channel_i = '0;
    query_channel_i      = '0;
    query_freq_i         = '0;
    out_stall_i          = 1'b0;
    psel                 = 1'b0;
    penable              = 1'b0;
    pwrite               = 1'b0;
    paddr                = '0;
    pwdata               = '0;
    idle_pct             = 35;

    repeat (9) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    // --- directed ---
    // band_count is 0 out of reset: nothing is searched, queries miss
    send_query(REQ_C2F, 0);
    send_query(REQ_F2C, 0);
    send_item(random_fields(REQ_NONE));        // unknown request, no result
    send_band(0, 1000, 2000, 0, 5);            // zero step, never matches
    send_band(1, 5000, 4990, 100, 10);         // end below start, only channel 10
    send_band(2, 100_000_000, 101_250_000, 25_000, 0);
    send_band(3, 0, FREQ_MAX, STEP_MAX, 65_500); // last channel lands past 16 bits
    drain();
    cfg_band_count(4);
    send_query(REQ_C2F, 10);                   // bands 1 and 2 both hold it, first wins
    send_query(REQ_C2F, 11);
    send_query(REQ_C2F, 50);
    send_query(REQ_C2F, 51);                   // miss
    send_query(REQ_C2F, 65_500);
    send_query(REQ_C2F, CHAN_MAX);
    send_query(REQ_F2C, 4950);                 // under a step below start -> first channel
    send_query(REQ_F2C, 5000);
    send_query(REQ_F2C, 4900);                 // falls through to band 3
    send_query(REQ_F2C, 100_075_007);
    send_query(REQ_F2C, FREQ_MAX);             // channel too large -> not found
    send_query(REQ_F2C, QF_MAX);
    send_band(0, FREQ_MAX, FREQ_MAX, STEP_MAX, CHAN_MAX);
    send_query(REQ_C2F, CHAN_MAX);
    send_query(REQ_F2C, FREQ_MAX);
    drain();

    // --- random ---
    // load every entry first so any band_count reads written entries only
    for (i = 0; i < MAX_BANDS; i++) send_item(random_band(i));
    phase_counts = '{16, 31, 1, 8, 0, 17, 16, 0, 0, 31};
    phase_counts[7] = BC_W'($urandom_range(31));
    phase_counts[8] = BC_W'($urandom_range(31));
    for (ph = 0; ph < NUM_PHASES; ph++) begin
      drain();
      cfg_band_count(phase_counts[ph]);
      // two phases run with no gaps and no stalls at all
      idle_pct = (ph == 2 || ph == 3) ? 0 : 35;
      sent = 0;
      while (sent < PHASE_ITEMS) begin
        pick = $urandom_range(99);
        if (pick < 15) item = random_band($urandom_range(MAX_BANDS - 1));
        else if (pick < 96) item = random_query(int'(sb.band_count));
        else item = random_fields(REQ_NONE);
        send_item(item);
        if (item.req != REQ_NONE) sent++;
      end
    end
    drain();

    if (sb.mismatches == 0) $display("end of test: clean");
    else $display("end of test: mismatches");
    $finish;
  end

endmodule
